// ----- design/psc_pkg.sv -----
`default_nettype none
package psc_pkg;

  localparam int RAW_W     = 16;
  localparam int CAL_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int TEMP_W    = 13;
  localparam int PRES_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_ONE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_TWO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_THREE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_FOUR  = 8'd3;

  localparam logic [15:0] DT_BASE   = 16'd20224;
  localparam logic [6:0]  C6_BIAS   = 7'd50;
  localparam logic signed [12:0] TEMP_BIAS = 13'sd200;
  localparam logic signed [17:0] SENS_BIAS = 18'sd24576;
  localparam logic signed [16:0] D1_BIAS   = 17'sd7168;
  localparam logic signed [21:0] P_BIAS    = 22'sd2500;
  localparam logic signed [21:0] P_MAX     = 22'sd65535;

  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
  } coef_t;

  function automatic coef_t unpack_coef(input logic [CAL_W-1:0] w1,
                                        input logic [CAL_W-1:0] w2,
                                        input logic [CAL_W-1:0] w3,
                                        input logic [CAL_W-1:0] w4);
    coef_t c;
    c.c1 = w1[15:1];
    c.c2 = {w3[5:0], w4[5:0]};
    c.c3 = w4[15:6];
    c.c4 = w3[15:6];
    c.c5 = {w1[0], w2[15:6]};
    c.c6 = w2[5:0];
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/psc_if.sv -----
`default_nettype none
interface psc_in_if;
  logic                          valid;
  logic                          ready;
  logic [psc_pkg::RAW_W-1:0]     pressure_raw;
  logic [psc_pkg::RAW_W-1:0]     temperature_raw;
  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface psc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [psc_pkg::TEMP_W-1:0]  temperature_out;
  logic [psc_pkg::PRES_W-1:0]         pressure_out;
  modport source (output valid, output temperature_out, output pressure_out, input ready);
  modport sink   (input valid, input temperature_out, input pressure_out, output ready);
endinterface

interface psc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [psc_pkg::CFG_IDX_W-1:0]   index;
  logic [psc_pkg::CAL_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/pressure_sensor_compensation_top.sv -----
// Throughput: one word per cycle while the output is not stalled; six
// register stages, each stage moves when it is empty or the stage after it
// moves, so bubbles are squeezed out.
// Reset (rst, synchronous): empties the pipeline and clears the four
// calibration words to zero.
`default_nettype none
module pressure_sensor_compensation_top (
  input  wire logic  clk,
  input  wire logic  rst,
  psc_cfg_if.sink    cfg,
  psc_in_if.sink     sample_in,
  psc_out_if.source  result_out
);
  import psc_pkg::*;

  localparam int NSTG = 6;

  logic [CAL_W-1:0] cal_word_one, cal_word_two, cal_word_three, cal_word_four;
  coef_t coef;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  // stage 0
  logic signed [15:0] s0_dt;
  logic signed [16:0] s0_d1m;
  // stage 1
  logic signed [22:0] s1_tprod;
  logic signed [25:0] s1_oprod;
  logic signed [26:0] s1_sprod;
  logic signed [16:0] s1_d1m;
  // stage 2
  logic signed [12:0] s2_temp;
  logic signed [16:0] s2_off;
  logic signed [17:0] s2_sens;
  logic signed [16:0] s2_d1m;
  // stage 3
  logic signed [34:0] s3_prod;
  logic signed [12:0] s3_temp;
  logic signed [16:0] s3_off;
  // stage 4
  logic signed [21:0] s4_x;
  logic signed [12:0] s4_temp;
  // stage 5 (output)
  logic signed [12:0] s5_temp;
  logic [15:0]        s5_pres;

  logic signed [15:0] dt_next;
  logic signed [16:0] d1m_next;
  logic signed [7:0]  c6p;
  logic signed [9:0]  c4m;
  logic signed [10:0] c3s;
  logic signed [16:0] off_next;
  logic signed [17:0] sens_next;
  logic signed [21:0] x_next;
  logic signed [25:0] x10;
  logic signed [21:0] p_full;
  logic [15:0]        pres_next;

  assign coef = unpack_coef(cal_word_one, cal_word_two, cal_word_three, cal_word_four);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_one   <= '0;
      cal_word_two   <= '0;
      cal_word_three <= '0;
      cal_word_four  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CAL_WORD_ONE:   cal_word_one   <= cfg.data;
        REG_CAL_WORD_TWO:   cal_word_two   <= cfg.data;
        REG_CAL_WORD_THREE: cal_word_three <= cfg.data;
        REG_CAL_WORD_FOUR:  cal_word_four  <= cfg.data;
        default: ;
      endcase
    end
  end

  // per-stage advance, fed back from the output side
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || result_out.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign sample_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= sample_in.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: temperature difference wraps at 16 bits
  assign dt_next  = $signed(sample_in.temperature_raw - (DT_BASE + {2'b00, coef.c5, 3'b000}));
  assign d1m_next = $signed({1'b0, sample_in.pressure_raw}) - D1_BIAS;

  // stage 1 operands
  assign c6p = $signed({1'b0, {1'b0, coef.c6} + C6_BIAS});
  assign c4m = $signed({~coef.c4[9], coef.c4[8:0]});   // c4 - 512
  assign c3s = $signed({1'b0, coef.c3});

  // stage 2 sums
  assign off_next  = 17'($signed(s1_oprod[25:12])) + $signed({3'b000, coef.c2, 2'b00});
  assign sens_next = 18'($signed(s1_sprod[26:10])) + $signed({3'b000, coef.c1}) + SENS_BIAS;

  // stage 4
  assign x_next = 22'($signed(s3_prod[34:14])) - 22'(s3_off);

  // stage 5: x*10 as shift-add, then floor shift and clamp
  assign x10    = (26'(s4_x) <<< 3) + (26'(s4_x) <<< 1);
  assign p_full = 22'($signed(x10[25:5])) + P_BIAS;
  always_comb begin
    if (p_full < 0) begin
      pres_next = '0;
    end else if (p_full > P_MAX) begin
      pres_next = '1;
    end else begin
      pres_next = p_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dt  <= dt_next;
      s0_d1m <= d1m_next;
    end
    if (en[1]) begin
      s1_tprod <= s0_dt * c6p;
      s1_oprod <= c4m * s0_dt;
      s1_sprod <= c3s * s0_dt;
      s1_d1m   <= s0_d1m;
    end
    if (en[2]) begin
      s2_temp <= $signed(s1_tprod[22:10]) + TEMP_BIAS;
      s2_off  <= off_next;
      s2_sens <= sens_next;
      s2_d1m  <= s1_d1m;
    end
    if (en[3]) begin
      s3_prod <= s2_sens * s2_d1m;
      s3_temp <= s2_temp;
      s3_off  <= s2_off;
    end
    if (en[4]) begin
      s4_x    <= x_next;
      s4_temp <= s3_temp;
    end
    if (en[5]) begin
      s5_temp <= s4_temp;
      s5_pres <= pres_next;
    end
  end

  assign result_out.valid           = v[NSTG-1];
  assign result_out.temperature_out = s5_temp;
  assign result_out.pressure_out    = s5_pres;

endmodule
`default_nettype wire

// ----- design/psc_checker.sv -----
`default_nettype none
module psc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cfg_ready,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [psc_pkg::TEMP_W-1:0]   temperature_out,
  input wire logic [psc_pkg::PRES_W-1:0]          pressure_out
);
  import psc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_out) && $stable(pressure_out))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input side stalls only under output back-pressure
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_out >= -13'sd3416 && temperature_out <= 13'sd3816)
    else $error("temperature out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_ready       (cfg.ready),
  .in_valid        (sample_in.valid),
  .in_ready        (sample_in.ready),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .temperature_out (result_out.temperature_out),
  .pressure_out    (result_out.pressure_out)
);
`default_nettype wire
